[rtl/pet_pkg.sv]
`default_nettype none

package pet_pkg;

  localparam int unsigned DataW  = 16;
  localparam int unsigned ErrW   = 17;
  localparam int unsigned TermW  = 32;
  localparam int unsigned LimW   = 31;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [CfgIdxW-1:0] CfgStepTime     = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgStepRate     = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgIntegralLimit = 2'd2;

  localparam logic [DataW-1:0] StepTimeRst      = 16'd655;
  localparam logic [DataW-1:0] StepRateRst      = 16'd25600;
  localparam logic [LimW-1:0]  IntegralLimitRst = 31'h7FFF_FFFF;

  // integral increment drops 16 fraction bits of step_time plus the halving
  localparam int unsigned IntShift  = 17;
  localparam int unsigned RateShift = 8;

  typedef struct packed {
    logic [DataW-1:0] step_time;
    logic [DataW-1:0] step_rate;
    logic [LimW-1:0]  integral_limit;
  } cfg_t;

  typedef struct packed {
    logic signed [ErrW-1:0]  last_error;
    logic signed [TermW-1:0] last_integral;
    logic                    first_sample;
  } hist_t;

  typedef struct packed {
    logic signed [ErrW-1:0]  error_term;
    logic signed [TermW-1:0] integral_term;
    logic signed [TermW-1:0] rate_term;
  } result_t;

endpackage

`default_nettype wire

[rtl/pet_cfg_regs.sv]
`default_nettype none

module pet_cfg_regs (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_we_i,
  input  wire logic [pet_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  wire logic [pet_pkg::LimW-1:0]          cfg_data_i,
  output pet_pkg::cfg_t                          cfg_o
);

  pet_pkg::cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.step_time      <= pet_pkg::StepTimeRst;
      cfg_q.step_rate      <= pet_pkg::StepRateRst;
      cfg_q.integral_limit <= pet_pkg::IntegralLimitRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        pet_pkg::CfgStepTime: begin
          cfg_q.step_time <= cfg_data_i[pet_pkg::DataW-1:0];
        end
        pet_pkg::CfgStepRate: begin
          cfg_q.step_rate <= cfg_data_i[pet_pkg::DataW-1:0];
        end
        pet_pkg::CfgIntegralLimit: begin
          cfg_q.integral_limit <= cfg_data_i;
        end
        default: begin
        end
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

[rtl/pet_calc.sv]
`default_nettype none

module pet_calc (
  input  wire logic signed [pet_pkg::DataW-1:0] measured_i,
  input  wire logic signed [pet_pkg::DataW-1:0] target_i,
  input  wire logic                             restart_i,
  input  wire pet_pkg::cfg_t                    cfg_i,
  input  wire pet_pkg::hist_t                   hist_i,
  output pet_pkg::result_t                      result_o
);

  logic signed [pet_pkg::ErrW-1:0]    err;
  logic signed [pet_pkg::ErrW-1:0]    prev_err;
  logic signed [pet_pkg::TermW-1:0]   prev_int;
  logic                               first;
  logic signed [pet_pkg::ErrW:0]      err_sum;
  logic signed [pet_pkg::ErrW:0]      err_diff;
  logic signed [pet_pkg::ErrW+pet_pkg::DataW+1:0] int_prod;
  logic signed [pet_pkg::ErrW+pet_pkg::DataW+1:0] rate_prod;
  logic signed [pet_pkg::TermW:0]     int_sum;
  logic signed [pet_pkg::TermW:0]     lim_pos;
  logic signed [pet_pkg::TermW:0]     lim_neg;
  logic signed [pet_pkg::TermW:0]     int_clamped;
  logic signed [pet_pkg::ErrW+pet_pkg::DataW+1:0] rate_shifted;

  // restart clears history ahead of this sample
  assign prev_err = restart_i ? '0 : hist_i.last_error;
  assign prev_int = restart_i ? '0 : hist_i.last_integral;
  assign first    = restart_i | hist_i.first_sample;

  assign err      = pet_pkg::ErrW'(target_i) - pet_pkg::ErrW'(measured_i);
  assign err_sum  = (pet_pkg::ErrW+1)'(err) + (pet_pkg::ErrW+1)'(prev_err);
  assign err_diff = (pet_pkg::ErrW+1)'(err) - (pet_pkg::ErrW+1)'(prev_err);

  assign int_prod  = (pet_pkg::ErrW+pet_pkg::DataW+2)'(err_sum)
                   * (pet_pkg::ErrW+pet_pkg::DataW+2)'($signed({1'b0, cfg_i.step_time}));
  assign rate_prod = (pet_pkg::ErrW+pet_pkg::DataW+2)'(err_diff)
                   * (pet_pkg::ErrW+pet_pkg::DataW+2)'($signed({1'b0, cfg_i.step_rate}));

  assign int_sum = (pet_pkg::TermW+1)'(int_prod >>> pet_pkg::IntShift)
                 + (pet_pkg::TermW+1)'(prev_int);

  assign lim_pos = $signed({2'b00, cfg_i.integral_limit});
  assign lim_neg = -lim_pos;

  always_comb begin
    if (int_sum > lim_pos) begin
      int_clamped = lim_pos;
    end else if (int_sum < lim_neg) begin
      int_clamped = lim_neg;
    end else begin
      int_clamped = int_sum;
    end
  end

  // magnitude stays below 2^26, no saturation reachable
  assign rate_shifted = rate_prod >>> pet_pkg::RateShift;

  assign result_o.error_term    = err;
  assign result_o.integral_term = int_clamped[pet_pkg::TermW-1:0];
  assign result_o.rate_term     = first ? '0 : rate_shifted[pet_pkg::TermW-1:0];

endmodule

`default_nettype wire

[rtl/pid_error_terms.sv]
// channel | direction | handshake               | payload
// config  | in        | cfg_we_i                | cfg_idx_i, cfg_data_i
// sample  | in        | in_valid_i / in_stall_o | measured_i, target_i, restart_i
// result  | out       | out_valid_o / out_stall_i | error_term_o, integral_term_o, rate_term_o
//
// result registered after the input register, one sample per clock while out_stall_i is low
// the rate is set by the registered update of the error and integral history
// reset clears history and loads the default config, no clearing pass
// a stall on the result side holds the result register and, once the input
// register is also full, raises in_stall_o in the same cycle
`default_nettype none

module pid_error_terms (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_we_i,
  input  wire logic [pet_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  wire logic [pet_pkg::LimW-1:0]         cfg_data_i,
  input  wire logic                             in_valid_i,
  output      logic                             in_stall_o,
  input  wire logic signed [pet_pkg::DataW-1:0] measured_i,
  input  wire logic signed [pet_pkg::DataW-1:0] target_i,
  input  wire logic                             restart_i,
  output      logic                             out_valid_o,
  input  wire logic                             out_stall_i,
  output      logic signed [pet_pkg::ErrW-1:0]  error_term_o,
  output      logic signed [pet_pkg::TermW-1:0] integral_term_o,
  output      logic signed [pet_pkg::TermW-1:0] rate_term_o
);

  pet_pkg::cfg_t    cfg;
  pet_pkg::hist_t   hist_q;
  pet_pkg::result_t calc_res;
  pet_pkg::result_t res_q;

  logic                             s1_valid_q;
  logic signed [pet_pkg::DataW-1:0] measured_q;
  logic signed [pet_pkg::DataW-1:0] target_q;
  logic                             restart_q;
  logic                             out_valid_q;
  logic                             out_free;
  logic                             s1_move;
  logic                             in_xfer;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign s1_move    = s1_valid_q && out_free;
  assign in_stall_o = s1_valid_q && !out_free;
  assign in_xfer    = in_valid_i && !in_stall_o;

  pet_cfg_regs u_cfg_regs (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  pet_calc u_calc (
    .measured_i (measured_q),
    .target_i   (target_q),
    .restart_i  (restart_q),
    .cfg_i      (cfg),
    .hist_i     (hist_q),
    .result_o   (calc_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_xfer) begin
      s1_valid_q <= 1'b1;
    end else if (s1_move) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      measured_q <= measured_i;
      target_q   <= target_i;
      restart_q  <= restart_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hist_q.last_error    <= '0;
      hist_q.last_integral <= '0;
      hist_q.first_sample  <= 1'b1;
    end else if (s1_move) begin
      hist_q.last_error    <= calc_res.error_term;
      hist_q.last_integral <= calc_res.integral_term;
      hist_q.first_sample  <= 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_move) begin
      res_q <= calc_res;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign error_term_o    = res_q.error_term;
  assign integral_term_o = res_q.integral_term;
  assign rate_term_o     = res_q.rate_term;

endmodule

`default_nettype wire

[rtl/pet_checker.sv]
`default_nettype none

module pet_checker (
  input wire logic                             clk_i,
  input wire logic                             rst_ni,
  input wire logic                             in_valid_i,
  input wire logic                             in_stall_o,
  input wire logic                             out_valid_o,
  input wire logic                             out_stall_i,
  input wire logic signed [pet_pkg::ErrW-1:0]  error_term_o,
  input wire logic signed [pet_pkg::TermW-1:0] integral_term_o,
  input wire logic signed [pet_pkg::TermW-1:0] rate_term_o
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(error_term_o) && $stable(integral_term_o)
                                   && $stable(rate_term_o))
    else $error("stalled result changed");

  // input side only backs up behind a waiting result
  a_no_stall_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled with empty result register");

  // a sample taken while no result is offered shows up after the input and result registers
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && !out_valid_o |=> ##1 out_valid_o)
    else $error("result missing after sample transfer");

  a_int_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> integral_term_o != {1'b1, {(pet_pkg::TermW-1){1'b0}}})
    else $error("integral beyond clamp range");

endmodule

bind pid_error_terms pet_checker u_pet_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_valid_i),
  .in_stall_o      (in_stall_o),
  .out_valid_o     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .error_term_o    (error_term_o),
  .integral_term_o (integral_term_o),
  .rate_term_o     (rate_term_o)
);

`default_nettype wire
